### hdl/hlfr_pkg.sv
// shared types, constants and codes of the header/length frame receiver
package hlfr_pkg;

  // default store depth and the widest store index the depth range allows
  localparam int unsigned BufLenDef = 64;
  localparam int unsigned MaxIdxW   = 8;

  // field widths
  localparam int unsigned ReqW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RidxW  = 6;
  localparam int unsigned CountW = 6;

  // frame rules
  localparam int unsigned AbandonLimit = 4;
  localparam int unsigned LengthBias   = 2;

  // header register reset values
  localparam logic [ByteW-1:0] HdrFirstRst  = 8'h5A;
  localparam logic [ByteW-1:0] HdrSecondRst = 8'hA5;

  typedef enum logic [ReqW-1:0] {
    REQ_BYTE = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  typedef enum logic {
    CFG_HDR_FIRST  = 1'b0,
    CFG_HDR_SECOND = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [ByteW-1:0] rx_value;
    logic [RidxW-1:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic              frame_ready;
    logic [CountW-1:0] fill_count;
    logic              byte_ignored;
    logic [ByteW-1:0]  frame_length;
    logic [ByteW-1:0]  read_data;
  } out_beat_t;

  typedef struct packed {
    logic             index;
    logic [ByteW-1:0] value;
  } cfg_beat_t;

  // write request from the frame logic into the store
  typedef struct packed {
    logic               en;
    logic [MaxIdxW-1:0] addr;
    logic [ByteW-1:0]   data;
  } store_wr_t;

endpackage

### hdl/hlfr_intf.sv
// valid/ready channel interfaces: request, result and configuration
interface hlfr_in_if;
  logic               valid;
  logic               ready;
  hlfr_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlfr_out_if;
  logic                valid;
  logic                ready;
  hlfr_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlfr_cfg_if;
  logic                valid;
  logic                ready;
  hlfr_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/header_length_frame_receiver_top.sv
// top level of the two-byte-header, length-framed byte receiver
//
//  channel  dir  beat contents                                   handshake
//  in_i     in   req_type, rx_value, read_index                  valid/ready
//  out_o    out  frame_ready, fill_count, byte_ignored,          valid/ready
//                frame_length, read_data
//  cfg_i    in   index (0 header_first, 1 header_second), value  valid/ready
//
//  one request per cycle sustained while results are taken; a result is presented
//  once its request has passed the request register, which loads with the store
//  read port on the accepting edge, and then the result register
//  reset clears the store (per-entry valid bits), fill index and ready flag and
//  loads the header reset values at once; no clearing pass
//  a stalled result holds in the result register while one more request waits
//  in the request register; configuration writes are always taken
module header_length_frame_receiver_top #(
  parameter int unsigned BUF_LEN = hlfr_pkg::BufLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hlfr_in_if.sink    in_i,
  hlfr_out_if.source out_o,
  hlfr_cfg_if.sink   cfg_i
);
  import hlfr_pkg::*;

  logic [ByteW-1:0] hdr_first_q;
  logic [ByteW-1:0] hdr_second_q;
  logic [ByteW-1:0] rd_data;
  logic             in_fire;
  store_wr_t        wr;

  // header registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HdrFirstRst;
      hdr_second_q <= HdrSecondRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.data.index))
        CFG_HDR_FIRST:  hdr_first_q  <= cfg_i.data.value;
        CFG_HDR_SECOND: hdr_second_q <= cfg_i.data.value;
        default: begin
        end
      endcase
    end
  end

  // frame logic
  hlfr_core #(
    .BUF_LEN (BUF_LEN)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_beat_i    (in_i.data),
    .in_ready_o   (in_i.ready),
    .in_fire_o    (in_fire),
    .out_valid_o  (out_o.valid),
    .out_beat_o   (out_o.data),
    .out_ready_i  (out_o.ready),
    .hdr_first_i  (hdr_first_q),
    .hdr_second_i (hdr_second_q),
    .rd_data_i    (rd_data),
    .wr_o         (wr)
  );

  // frame store, read as each request is taken
  hlfr_store #(
    .BUF_LEN (BUF_LEN)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_en_i    (in_fire),
    .rd_index_i (in_i.data.read_index),
    .rd_data_o  (rd_data)
  );

endmodule

### hdl/hlfr_store.sv
// frame store: byte memory with per-entry valid bits and a registered read port
module hlfr_store #(
  parameter int unsigned BUF_LEN = hlfr_pkg::BufLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hlfr_pkg::store_wr_t          wr_i,
  input  logic                         rd_en_i,
  input  logic [hlfr_pkg::RidxW-1:0]   rd_index_i,
  output logic [hlfr_pkg::ByteW-1:0]   rd_data_o
);
  import hlfr_pkg::*;

  localparam int unsigned IdxW = $clog2(BUF_LEN);
  localparam int unsigned RdW  = RidxW + IdxW;

  logic [ByteW-1:0]   mem_q [BUF_LEN];
  logic [BUF_LEN-1:0] vld_q;

  logic [IdxW-1:0]  wr_addr;
  logic [RdW-1:0]   rd_wide;
  logic [IdxW-1:0]  rd_addr;
  logic             rd_in_range;
  logic             rd_hit;

  logic             rd_ok_q;
  logic             rd_vld_q;
  logic             byp_q;
  logic [ByteW-1:0] rd_mem_q;
  logic [ByteW-1:0] byp_data_q;

  // address decode
  assign wr_addr     = wr_i.addr[IdxW-1:0];
  assign rd_wide     = RdW'(rd_index_i);
  assign rd_addr     = rd_wide[IdxW-1:0];
  assign rd_in_range = rd_wide < RdW'(BUF_LEN);
  assign rd_hit      = wr_i.en && (wr_addr == rd_addr);

  // memory write and read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_i.data;
    end
    if (rd_en_i && rd_in_range) begin
      rd_mem_q   <= mem_q[rd_addr];
      byp_data_q <= wr_i.data;
    end
  end

  // valid bits, cleared at reset, and read status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_ok_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= rd_in_range;
        if (rd_in_range) begin
          rd_vld_q <= vld_q[rd_addr];
          byp_q    <= rd_hit;
        end
      end
    end
  end

  // a write landing on the same edge as the read wins over the old data
  always_comb begin
    if (!rd_ok_q) begin
      rd_data_o = '0;
    end else if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_mem_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

### hdl/hlfr_core.sv
// frame logic: request register, fill index and flag update, result register
module hlfr_core #(
  parameter int unsigned BUF_LEN = hlfr_pkg::BufLenDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  hlfr_pkg::in_beat_t          in_beat_i,
  output logic                        in_ready_o,
  output logic                        in_fire_o,
  output logic                        out_valid_o,
  output hlfr_pkg::out_beat_t         out_beat_o,
  input  logic                        out_ready_i,
  input  logic [hlfr_pkg::ByteW-1:0]  hdr_first_i,
  input  logic [hlfr_pkg::ByteW-1:0]  hdr_second_i,
  input  logic [hlfr_pkg::ByteW-1:0]  rd_data_i,
  output hlfr_pkg::store_wr_t         wr_o
);
  import hlfr_pkg::*;

  localparam int unsigned IdxW = $clog2(BUF_LEN);
  localparam int unsigned CmpW = ((IdxW > ByteW) ? IdxW : ByteW) + 1;
  localparam int unsigned ExtW = IdxW + CountW;

  logic            s1_valid_q;
  in_beat_t        s1_q;
  logic            out_valid_q;
  out_beat_t       out_q;

  logic [IdxW-1:0]  fill_q, fill_d;
  logic             rdy_q, rdy_d;
  logic [ByteW-1:0] b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;

  logic             s1_fire;
  req_e             req;
  logic             ignored;
  logic [ByteW-1:0] rdata;
  logic [IdxW-1:0]  adv_fill;
  logic [IdxW-1:0]  nxt_fill;
  logic [CmpW-1:0]  nxt_cmp;
  logic [CmpW-1:0]  len_cmp;
  logic             hdr_ok;
  logic [ExtW-1:0]  fill_ext;
  out_beat_t        res;

  // handshakes: the request stage moves on whenever the result slot frees
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire_o  = in_valid_i && in_ready_o;
  assign req        = req_e'(s1_q.req_type);

  // index arithmetic for a stored byte
  assign adv_fill = (fill_q == IdxW'(BUF_LEN - 1)) ? '0 : fill_q + IdxW'(1);
  assign hdr_ok   = (b0_d == hdr_first_i);
  assign nxt_fill = hdr_ok ? adv_fill : '0;
  assign nxt_cmp  = CmpW'(nxt_fill);
  assign len_cmp  = CmpW'(b2_d) + CmpW'(LengthBias);

  // next state for the request held in the stage register
  always_comb begin
    fill_d  = fill_q;
    rdy_d   = rdy_q;
    b0_d    = b0_q;
    b1_d    = b1_q;
    b2_d    = b2_q;
    ignored = 1'b0;
    rdata   = '0;
    wr_o    = '0;
    unique case (req)
      REQ_BYTE: begin
        if (rdy_q) begin
          ignored = 1'b1;
        end else begin
          wr_o.en   = s1_fire;
          wr_o.addr = MaxIdxW'(fill_q);
          wr_o.data = s1_q.rx_value;
          if (fill_q == IdxW'(0)) b0_d = s1_q.rx_value;
          if (fill_q == IdxW'(1)) b1_d = s1_q.rx_value;
          if (fill_q == IdxW'(2)) b2_d = s1_q.rx_value;
          // complete frame, abandoned frame, or keep filling
          if (hdr_ok && (b1_d == hdr_second_i) && (nxt_cmp > len_cmp)) begin
            fill_d = '0;
            rdy_d  = 1'b1;
          end else if ((nxt_cmp > CmpW'(AbandonLimit)) && (b1_d != hdr_second_i)) begin
            fill_d = '0;
          end else begin
            fill_d = nxt_fill;
          end
        end
      end
      REQ_ACK: begin
        rdy_d = 1'b0;
      end
      REQ_READ: begin
        rdata = rd_data_i;
      end
      default: begin
      end
    endcase
  end

  // result assembly
  assign fill_ext = ExtW'(fill_d);
  always_comb begin
    res.frame_ready  = rdy_d;
    res.fill_count   = fill_ext[CountW-1:0];
    res.byte_ignored = ignored;
    res.frame_length = b2_d;
    res.read_data    = rdata;
  end

  // control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      rdy_q       <= 1'b0;
      b0_q        <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
    end else begin
      if (in_fire_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        fill_q      <= fill_d;
        rdy_q       <= rdy_d;
        b0_q        <= b0_d;
        b1_q        <= b1_d;
        b2_q        <= b2_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire_o) begin
      s1_q <= in_beat_i;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

### hdl/hlfr_chk.sv
// port-level checks on the receiver results, bound to the top level
module hlfr_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input hlfr_pkg::out_beat_t out_beat_i
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i))
    else $error("result beat changed while stalled");

  // a byte is only dropped while a frame waits
  a_ignored_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_beat_i.byte_ignored |-> out_beat_i.frame_ready)
    else $error("byte dropped without a waiting frame");

  // a waiting frame always leaves the fill index at zero
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_beat_i.frame_ready |-> out_beat_i.fill_count == '0)
    else $error("fill index not cleared with frame waiting");

endmodule

bind header_length_frame_receiver_top hlfr_chk u_hlfr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.data)
);

### bench/tb_header_length_frame_receiver_top.sv
// testbench for the header/length frame receiver: random requests against a built-in predictor
module tb_header_length_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hlfr_pkg::*;

  localparam int unsigned BufLen      = BufLenDef;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned PhaseItems  = 190;
  // request code the block leaves unused
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  logic clk_i;
  logic rst_ni;

  hlfr_in_if  in_if ();
  hlfr_out_if out_if ();
  hlfr_cfg_if cfg_if ();

  header_length_frame_receiver_top #(
    .BUF_LEN(BufLen)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // predictor state: a copy of the store, fill index, ready flag and headers
  logic [ByteW-1:0] frame_bytes [BufLen];
  int unsigned      fill_pos;
  logic             frame_waiting;
  logic [ByteW-1:0] hdr_first;
  logic [ByteW-1:0] hdr_second;

  in_beat_t  pending_requests [$];
  out_beat_t predicted_status [$];

  int unsigned fail_cnt;
  int unsigned beats_taken;
  int unsigned results_seen;
  int unsigned random_items;
  int unsigned settings_seen;
  int unsigned frames_completed;
  int unsigned frames_abandoned;
  int unsigned index_wraps;
  int unsigned bytes_dropped;

  // status the block reports after one request beat
  function automatic out_beat_t receive_step(in_beat_t req);
    out_beat_t res;
    res = '0;
    case (req.req_type)
      REQ_BYTE: begin
        if (frame_waiting) begin
          res.byte_ignored = 1'b1;
          bytes_dropped++;
        end else begin
          frame_bytes[fill_pos] = req.rx_value;
          // index only moves on while byte 0 holds the first header
          if (frame_bytes[0] == hdr_first) begin
            if (fill_pos + 1 >= BufLen) begin
              fill_pos = 0;
              index_wraps++;
            end else begin
              fill_pos = fill_pos + 1;
            end
          end else begin
            fill_pos = 0;
          end
          if (frame_bytes[0] == hdr_first && frame_bytes[1] == hdr_second &&
              fill_pos > int'(frame_bytes[2]) + LengthBias) begin
            fill_pos      = 0;
            frame_waiting = 1'b1;
            frames_completed++;
          end else if (fill_pos > AbandonLimit && frame_bytes[1] != hdr_second) begin
            fill_pos = 0;
            frames_abandoned++;
          end
        end
      end
      REQ_ACK: frame_waiting = 1'b0;
      REQ_READ: begin
        if (req.read_index < BufLen) res.read_data = frame_bytes[req.read_index];
      end
      default: ;
    endcase
    res.frame_ready  = frame_waiting;
    res.fill_count   = fill_pos[CountW-1:0];
    res.frame_length = frame_bytes[2];
    return res;
  endfunction

  // sender: bursts of beats with random gaps, fed from the pending queue
  int unsigned gap_left;
  int unsigned burst_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      gap_left    = 0;
      burst_left  = 8;
    end else begin
      // beat taken: predict its status
      if (in_if.valid && in_if.ready) begin
        predicted_status.push_back(receive_step(in_if.data));
        beats_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_if.data  <= pending_requests.pop_front();
          in_if.valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // receiver: drives ready from a random stall pattern that it refreshes, compares each result beat
  logic [7:0]  stall_pat;
  int unsigned stall_cycle;

  always @(posedge clk_i or negedge rst_ni) begin : result_side
    out_beat_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_pat    = '1;
      stall_cycle  = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (predicted_status.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_cnt++;
        end else begin
          want = predicted_status.pop_front();
          check_field("frame_ready", want.frame_ready, out_if.data.frame_ready);
          check_field("fill_count", want.fill_count, out_if.data.fill_count);
          check_field("byte_ignored", want.byte_ignored, out_if.data.byte_ignored);
          check_field("frame_length", want.frame_length, out_if.data.frame_length);
          check_field("read_data", want.read_data, out_if.data.read_data);
          results_seen++;
        end
      end
      if (stall_cycle[4:0] == 0) begin
        if ($urandom_range(0, 2) == 0) stall_pat = '1;
        else stall_pat = 8'($urandom()) | (8'd1 << $urandom_range(0, 7));
      end
      out_if.ready <= stall_pat[stall_cycle[2:0]];
      stall_cycle++;
    end
  end

  // watchdog: too long without any beat on any channel
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_req(logic [ReqW-1:0] kind, logic [ByteW-1:0] rx,
                           logic [RidxW-1:0] ridx, bit counted);
    in_beat_t req;
    req.req_type   = kind;
    req.rx_value   = rx;
    req.read_index = ridx;
    pending_requests.push_back(req);
    if (counted) random_items++;
  endtask

  // wait until every beat is taken and every result is back
  task automatic settle();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || in_if.valid || predicted_status.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_header(cfg_idx_e idx, logic [ByteW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {idx, val};
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_HDR_FIRST) hdr_first = val;
    else hdr_second = val;
  endtask

  // mostly well-formed frames with random content, plus broken frames, reads and noise
  task automatic queue_random(int unsigned n);
    int unsigned target;
    int unsigned len;
    int unsigned pick;
    logic [ReqW-1:0] kind;
    target = random_items + n;
    while (random_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 3) == 0) queue_req(REQ_ACK, 8'($urandom()), 6'($urandom()), 1);
        // a few long frames reach the end of the store
        if ($urandom_range(0, 49) == 0) len = $urandom_range(58, 66);
        else len = $urandom_range(0, 6);
        queue_req(REQ_BYTE, hdr_first, 6'($urandom()), 1);
        queue_req(REQ_BYTE, hdr_second, 6'($urandom()), 1);
        queue_req(REQ_BYTE, 8'(len), 6'($urandom()), 1);
        repeat (len) queue_req(REQ_BYTE, 8'($urandom()), 6'($urandom()), 1);
        if ($urandom_range(0, 3) == 0) queue_req(REQ_BYTE, 8'($urandom()), 6'($urandom()), 0);
        repeat ($urandom_range(0, 3)) begin
          queue_req(REQ_READ, 8'($urandom()),
                    6'($urandom_range(0, (len + 3 > BufLen - 1) ? BufLen - 1 : len + 3)), 1);
        end
        if ($urandom_range(0, 9) != 0) queue_req(REQ_ACK, 8'($urandom()), 6'($urandom()), 1);
      end else if (pick < 70) begin
        // first header then a second byte that is most likely wrong
        queue_req(REQ_BYTE, hdr_first, 6'($urandom()), 1);
        queue_req(REQ_BYTE, 8'($urandom()), 6'($urandom()), 1);
        repeat ($urandom_range(0, 6)) queue_req(REQ_BYTE, 8'($urandom()), 6'($urandom()), 1);
      end else if (pick < 85) begin
        queue_req(REQ_READ, 8'($urandom()), 6'($urandom()), 1);
      end else begin
        kind = 2'($urandom_range(0, 3));
        queue_req(kind, 8'($urandom()), 6'($urandom()), kind != ReqUnused);
      end
    end
  endtask

  // header settings after the reset values: both extremes, random, equal headers
  logic [ByteW-1:0] first_set  [4];
  logic [ByteW-1:0] second_set [4];

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    fill_pos      = 0;
    frame_waiting = 1'b0;
    hdr_first     = HdrFirstRst;
    hdr_second    = HdrSecondRst;
    fail_cnt      = 0;
    beats_taken   = 0;
    results_seen  = 0;
    random_items  = 0;
    settings_seen = 1;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads of the cleared store, lone acknowledge, unused code, a stray byte
    queue_req(REQ_READ, 8'hFF, 6'd0, 1);
    queue_req(REQ_READ, 8'h00, 6'h3F, 1);
    queue_req(REQ_ACK, 8'h00, 6'h00, 1);
    queue_req(ReqUnused, 8'hFF, 6'h3F, 0);
    queue_req(REQ_BYTE, 8'h00, 6'h00, 1);
    // complete frame, then a byte dropped while it waits, reads of the frame and its acknowledge
    queue_req(REQ_BYTE, hdr_first, 6'h00, 1);
    queue_req(REQ_BYTE, hdr_second, 6'h00, 1);
    queue_req(REQ_BYTE, 8'd2, 6'h00, 1);
    queue_req(REQ_BYTE, 8'h00, 6'h00, 1);
    queue_req(REQ_BYTE, 8'hFF, 6'h00, 1);
    queue_req(REQ_BYTE, 8'h11, 6'h00, 0);
    queue_req(REQ_READ, 8'h00, 6'd0, 1);
    queue_req(REQ_READ, 8'h00, 6'd1, 1);
    queue_req(REQ_READ, 8'h00, 6'd2, 1);
    queue_req(REQ_READ, 8'h00, 6'd4, 1);
    queue_req(REQ_ACK, 8'h00, 6'h00, 1);
    // wrong second header: frame abandoned once the index passes the limit
    queue_req(REQ_BYTE, hdr_first, 6'h00, 1);
    queue_req(REQ_BYTE, 8'h00, 6'h00, 1);
    queue_req(REQ_BYTE, 8'h33, 6'h00, 1);
    queue_req(REQ_BYTE, 8'h44, 6'h00, 1);
    queue_req(REQ_BYTE, 8'h55, 6'h00, 1);
    queue_req(REQ_READ, 8'h00, 6'd1, 1);
    // zero-length frame
    queue_req(REQ_BYTE, hdr_first, 6'h00, 1);
    queue_req(REQ_BYTE, hdr_second, 6'h00, 1);
    queue_req(REQ_BYTE, 8'd0, 6'h00, 1);
    queue_req(REQ_ACK, 8'h00, 6'h00, 1);

    queue_random(250);

    first_set[0] = 8'h00;
    second_set[0] = 8'hFF;
    first_set[1] = 8'hFF;
    second_set[1] = 8'h00;
    first_set[2] = 8'($urandom());
    second_set[2] = 8'($urandom());
    first_set[3] = HdrFirstRst;
    second_set[3] = HdrFirstRst;
    for (int s = 0; s < 4; s++) begin
      settle();
      write_header(CFG_HDR_FIRST, first_set[s]);
      write_header(CFG_HDR_SECOND, second_set[s]);
      settings_seen++;
      queue_random(PhaseItems);
    end

    settle();
    if (predicted_status.size() != 0) begin
      $error("%0d results never arrived", predicted_status.size());
      fail_cnt++;
    end
    $display("covered %0d request beats and %0d results under %0d header settings",
             beats_taken, results_seen, settings_seen);
    $display("frames: %0d completed, %0d abandoned, %0d index wraps, %0d bytes dropped",
             frames_completed, frames_abandoned, index_wraps, bytes_dropped);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hdl/hlfr_pkg.sv
hdl/hlfr_intf.sv
hdl/hlfr_store.sv
hdl/hlfr_core.sv
hdl/header_length_frame_receiver_top.sv
hdl/hlfr_chk.sv
bench/tb_header_length_frame_receiver_top.sv
